// ===== src/sdrm_pkg.sv =====
package sdrm_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int IO_WIDTH = 64;
    localparam int BITS_PER_STAGE = 4;

    typedef enum logic [1:0] {
        KIND_EXACT = 2'd0,
        KIND_QUOT  = 2'd1,
        KIND_REM   = 2'd2,
        KIND_MOD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_INEXACT = 2'd2
    } status_t;

endpackage

// ===== src/sdrm_stage.sv =====
// one pipeline stage of the restoring divider: retires BITS quotient bits
module sdrm_stage #(
    parameter int W = 64,
    parameter int BITS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_rem,
    input  logic [W-1:0] in_quo,
    input  logic [W-1:0] in_dvs,
    input  logic [1:0]   in_kind,
    input  logic         in_an,
    input  logic         in_bn,
    input  logic         in_zero,
    input  logic [W-1:0] in_b,
    output logic         out_valid,
    output logic [W-1:0] out_rem,
    output logic [W-1:0] out_quo,
    output logic [W-1:0] out_dvs,
    output logic [1:0]   out_kind,
    output logic         out_an,
    output logic         out_bn,
    output logic         out_zero,
    output logic [W-1:0] out_b
);

    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;
    logic         valid_reg;
    logic [W-1:0] rem_reg, quo_reg, dvs_reg, b_reg;
    logic [1:0]   kind_reg;
    logic         an_reg, bn_reg, zero_reg;

    // shift in dividend bits one at a time, subtract when it fits
    always_comb begin
        logic [W:0] trial;
        rem_next = in_rem;
        quo_next = in_quo;
        for (int i = 0; i < BITS; i++) begin
            trial = {rem_next, quo_next[W-1]} - {1'b0, in_dvs};
            quo_next = {quo_next[W-2:0], ~trial[W]};
            rem_next = trial[W] ? {rem_next[W-2:0], in_quo[W-1-i]} : trial[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= in_dvs;
            kind_reg <= in_kind;
            an_reg   <= in_an;
            bn_reg   <= in_bn;
            zero_reg <= in_zero;
            b_reg    <= in_b;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_dvs   = dvs_reg;
    assign out_kind  = kind_reg;
    assign out_an    = an_reg;
    assign out_bn    = bn_reg;
    assign out_zero  = zero_reg;
    assign out_b     = b_reg;

endmodule

// ===== src/signed_divide_rem_mod_unit_top.sv =====
// Pipelined signed divider: one transaction enters every cycle while the output
// is not stalled. One stage takes the operand magnitudes, each divider
// stage retires four quotient bits, and a last stage applies signs, the
// floored correction and the status. Every stage
// holds under back-pressure, so a stall loses nothing. Kind 0 is exact divide,
// 1 truncated quotient, 2 remainder (dividend sign), 3 floored modulo (divisor
// sign); status 1 marks a zero divisor, 2 an inexact exact divide, value 0 then.
module signed_divide_rem_mod_unit_top #(
    parameter int DATA_WIDTH = sdrm_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic signed [63:0] s_dividend,
    input  logic signed [63:0] s_divisor,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [63:0] m_value,
    output logic [1:0]  m_status
);

    localparam int W = DATA_WIDTH;
    localparam int B = sdrm_pkg::BITS_PER_STAGE;
    localparam int NS = (W + B - 1) / B;
    localparam int WP = NS * B;

    logic en;
    logic out_valid_reg;
    logic [63:0] value_reg;
    logic [1:0]  status_reg;

    // whole pipe advances unless the output is full and stalled
    assign en = !out_valid_reg || m_ready;
    assign s_ready = en;

    // front stage: magnitudes
    logic [W-1:0] a_w, b_w;
    logic an, bn;
    logic v0_reg;
    logic [WP-1:0] ma_reg, mb_reg, b0_reg;
    logic [1:0] k0_reg;
    logic an0_reg, bn0_reg, z0_reg;

    assign a_w = s_dividend[W-1:0];
    assign b_w = s_divisor[W-1:0];
    assign an = a_w[W-1];
    assign bn = b_w[W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg  <= WP'(an ? (~a_w + 1'b1) : a_w);
            mb_reg  <= WP'(bn ? (~b_w + 1'b1) : b_w);
            b0_reg  <= WP'(b_w);
            k0_reg  <= s_kind;
            an0_reg <= an;
            bn0_reg <= bn;
            z0_reg  <= (b_w == '0);
        end
    end

    // divider stages
    logic [NS:0]       v_c, an_c, bn_c, z_c;
    logic [WP-1:0]     rem_c [NS+1];
    logic [WP-1:0]     quo_c [NS+1];
    logic [WP-1:0]     dvs_c [NS+1];
    logic [WP-1:0]     b_c   [NS+1];
    logic [1:0]        k_c   [NS+1];

    assign v_c[0]   = v0_reg;
    assign rem_c[0] = '0;
    assign quo_c[0] = ma_reg;
    assign dvs_c[0] = mb_reg;
    assign b_c[0]   = b0_reg;
    assign k_c[0]   = k0_reg;
    assign an_c[0]  = an0_reg;
    assign bn_c[0]  = bn0_reg;
    assign z_c[0]   = z0_reg;

    for (genvar g = 0; g < NS; g++) begin : g_div
        sdrm_stage #(.W(WP), .BITS(B)) u_stage (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(v_c[g]), .in_rem(rem_c[g]), .in_quo(quo_c[g]),
            .in_dvs(dvs_c[g]), .in_kind(k_c[g]), .in_an(an_c[g]),
            .in_bn(bn_c[g]), .in_zero(z_c[g]), .in_b(b_c[g]),
            .out_valid(v_c[g+1]), .out_rem(rem_c[g+1]), .out_quo(quo_c[g+1]),
            .out_dvs(dvs_c[g+1]), .out_kind(k_c[g+1]), .out_an(an_c[g+1]),
            .out_bn(bn_c[g+1]), .out_zero(z_c[g+1]), .out_b(b_c[g+1])
        );
    end

    // back stage: signs, floored correction, status
    logic [W-1:0] mq, mr, q, r, res;
    logic [1:0]   st;
    logic [63:0]  value_next;

    assign mq = quo_c[NS][W-1:0];
    assign mr = rem_c[NS][W-1:0];
    assign q  = (an_c[NS] != bn_c[NS]) ? (~mq + 1'b1) : mq;
    assign r  = an_c[NS] ? (~mr + 1'b1) : mr;

    always_comb begin
        res = '0;
        st  = sdrm_pkg::ST_OK;
        if (z_c[NS]) begin
            st = sdrm_pkg::ST_DIVZERO;
        end else begin
            case (sdrm_pkg::kind_t'(k_c[NS]))
                sdrm_pkg::KIND_EXACT: begin
                    if (mr == '0) res = q;
                    else st = sdrm_pkg::ST_INEXACT;
                end
                sdrm_pkg::KIND_QUOT: res = q;
                sdrm_pkg::KIND_REM:  res = r;
                sdrm_pkg::KIND_MOD: begin
                    if (mr != '0 && an_c[NS] != bn_c[NS]) res = r + b_c[NS][W-1:0];
                    else res = r;
                end
                default: res = q;
            endcase
        end
        value_next = 64'(signed'(res));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_c[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg  <= value_next;
            status_reg <= st;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = value_reg;
    assign m_status = status_reg;

    // a flagged result carries value zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != sdrm_pkg::ST_OK |-> m_value == 64'd0)
        else $error("flagged result with nonzero value");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("stalled result changed");

    // input ready exactly when the output can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready out of step with output");

endmodule

// ===== tb/sv/signed_divide_rem_mod_checker.sv =====
module signed_divide_rem_mod_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [63:0] s_dividend,
    input  logic signed [63:0] s_divisor,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [63:0] m_value,
    input  logic [1:0]         m_status,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [63:0]       value;
        sdrm_pkg::status_t status;
    } div_result_t;

    div_result_t quotient_q[$];

    // signed divide with truncated and floored variants
    function automatic div_result_t compute_division(sdrm_pkg::kind_t k, logic [63:0] a,
                                                     logic [63:0] b);
        div_result_t res;
        logic an, bn;
        logic [63:0] ma, mb, mq, mr, q, r;
        res.value = '0;
        res.status = sdrm_pkg::ST_OK;
        if (b == 64'd0) begin
            res.status = sdrm_pkg::ST_DIVZERO;
            return res;
        end
        an = a[63];
        bn = b[63];
        ma = an ? -a : a;
        mb = bn ? -b : b;
        mq = ma / mb;
        mr = ma % mb;
        q = (an != bn) ? -mq : mq;
        r = an ? -mr : mr;
        case (k)
            sdrm_pkg::KIND_EXACT: begin
                if (mr == 64'd0) res.value = q;
                else res.status = sdrm_pkg::ST_INEXACT;
            end
            sdrm_pkg::KIND_QUOT: res.value = q;
            sdrm_pkg::KIND_REM: res.value = r;
            default: begin
                if (mr != 64'd0 && an != bn) r = r + b;
                res.value = r;
            end
        endcase
        return res;
    endfunction

    assign pending_count = quotient_q.size();

    // predict on input transaction, compare on result transaction
    always @(posedge aclk) begin
        div_result_t got;
        div_result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                quotient_q.push_back(compute_division(sdrm_pkg::kind_t'(s_kind),
                                                      s_dividend, s_divisor));
            if (m_valid && m_ready) begin
                if (quotient_q.size() == 0) begin
                    $error("unexpected result transaction value=%0d", m_value);
                    errs++;
                end else begin
                    want = quotient_q.pop_front();
                    got.value = m_value;
                    got.status = sdrm_pkg::status_t'(m_status);
                    if (got.value !== want.value) begin
                        $error("value: expected %0d actual %0d",
                               $signed(want.value), $signed(got.value));
                        errs++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== tb/sv/signed_divide_rem_mod_unit_top_tb.sv =====
module signed_divide_rem_mod_unit_top_tb;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_kind = '0;
    logic signed [63:0] s_dividend = '0;
    logic signed [63:0] s_divisor = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [63:0] m_value;
    logic [1:0]         m_status;
    int                 fail_count;
    int                 pending_count;
    bit                 quiet_phase = 0;
    bit                 long_hold = 0;

    always #5 aclk = ~aclk;

    signed_divide_rem_mod_unit_top dut (.*);

    signed_divide_rem_mod_checker chk (.*);

    // interesting operand values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '1;
            3: return 64'd0;
            4: return 64'(int'($urandom_range(0, 40)) - 20);
            5: return {32'd0, $urandom()};
            6: return {{32{1'b1}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // one input transaction, with an occasional random idle gap before it when allowed
    task automatic send_item(sdrm_pkg::kind_t k, logic [63:0] a, logic [63:0] b,
                             bit allow_gap);
        if (allow_gap && !quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1;
        s_kind <= k;
        s_dividend <= a;
        s_divisor <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drop_valid();
        s_valid <= 0;
    endtask

    // receiver stall bursts
    initial begin
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 0;
                repeat (60) @(posedge aclk);
                long_hold = 0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [63:0] edges [6];
        int k;
        edges = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, '1, 64'd0, 64'd1, 64'd7};
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, every kind, zero and minus-one divisors, inexact
        for (k = 0; k < 4; k++) begin
            send_item(sdrm_pkg::kind_t'(k), 64'h8000_0000_0000_0000, '1, 0);
            send_item(sdrm_pkg::kind_t'(k), 64'd7, 64'd0, 0);
            send_item(sdrm_pkg::kind_t'(k), 64'd7, 64'hffff_ffff_ffff_fffe, 0);
            send_item(sdrm_pkg::kind_t'(k), 64'hffff_ffff_ffff_fff9, 64'd2, 0);
            send_item(sdrm_pkg::kind_t'(k), edges[k], edges[k + 1], 0);
        end
        send_item(sdrm_pkg::KIND_EXACT, 64'd12, 64'hffff_ffff_ffff_fffd, 0);
        send_item(sdrm_pkg::KIND_MOD, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0);
        drop_valid();
        // sender waits for everything to drain
        wait (pending_count == 0);
        @(posedge aclk);
        // receiver holds off while sender keeps offering
        long_hold = 1;
        for (k = 0; k < 1200; k++) begin
            if (k == 1000) quiet_phase = 1;
            send_item(sdrm_pkg::kind_t'($urandom_range(0, 3)), pick_operand(),
                      pick_operand(), k > 40);
        end
        drop_valid();
        wait (pending_count == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
